// File: hw/rtl/triangle_primitive_assembler_unit_macros.svh
// Assertion macros used by the checker file of the triangle primitive assembler.
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLER_UNIT_MACROS_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPA_ASSERT_NOW(label_, ante_, cons_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |-> (cons_)) \
    else $error("triangle primitive assembler assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TPA_ASSERT_NEXT(label_, ante_, cons_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |=> (cons_)) \
    else $error("triangle primitive assembler assertion failed");

`endif

// File: hw/rtl/tpa_pkg.sv
// Types, constants and arithmetic helpers of the triangle primitive assembler.
package tpa_pkg;

  localparam int unsigned NumCorners = 3;
  localparam int unsigned SlotW      = 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [SlotW-1:0] LastCorner = SlotW'(NumCorners - 1);

  localparam logic [1:0] ActBegin  = 2'd0;
  localparam logic [1:0] ActVertex = 2'd1;
  localparam logic [1:0] ActEnd    = 2'd2;

  localparam logic [1:0] PrimFan   = 2'd1;
  localparam logic [1:0] PrimStrip = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgReverse   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDepth     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvHeight = 2'd2;

  localparam logic signed [31:0] SMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMin = 32'sh8000_0000;

  typedef logic [SlotW-1:0] slot_idx_t;
  typedef slot_idx_t [NumCorners-1:0] slot_order_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         prim_kind;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_s;
    logic signed [31:0] tex_t;
    logic               last;
  } out_req_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] s;
    logic signed [31:0] t;
  } vtx_t;

  typedef struct packed {
    vtx_t        vtx;
    slot_idx_t   slot;
    logic        emit;
    slot_order_t order;
  } rec_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] sum;
    sum = {a[31], a} + {b[31], b};
    if (sum[32] != sum[31]) begin
      return sum[32] ? SMin : SMax;
    end
    return sum[31:0];
  endfunction

  function automatic logic signed [31:0] tex_scale(input logic signed [63:0] prod);
    logic signed [47:0] quo;
    quo = prod[63:16];
    if (&quo[47:31] || ~|quo[47:31]) begin
      return quo[31:0];
    end
    return quo[47] ? SMin : SMax;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    if (v == SMin) begin
      return SMax;
    end
    return -v;
  endfunction

endpackage

// File: hw/rtl/tpa_front.sv
// Front end: configuration registers, item classification, slot bookkeeping and vertex maths.
module tpa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tpa_pkg::in_req_t              in_req_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tpa_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output tpa_pkg::rec_t                 push_rec_o
);

  logic               reverse_q;
  logic signed [31:0] depth_q;
  logic [30:0]        inv_q;

  tpa_pkg::slot_idx_t   fill_q, fill_d, fill_inc;
  tpa_pkg::slot_order_t order_q, order_d, emit_order;
  logic [1:0]           mode_q, mode_d;
  logic                 tri_done;

  logic advance, accept, accept_vtx;

  logic                 a_valid_q;
  logic signed [31:0]   a_x_q, a_y_q, a_z_q;
  tpa_pkg::slot_idx_t   a_slot_q;
  logic                 a_emit_q;
  tpa_pkg::slot_order_t a_order_q;

  logic                 b_valid_q;
  logic signed [31:0]   b_x_q, b_y_q, b_z_q;
  logic signed [63:0]   b_prod_s_q, b_prod_t_q;
  tpa_pkg::slot_idx_t   b_slot_q;
  logic                 b_emit_q;
  tpa_pkg::slot_order_t b_order_q;

  logic signed [31:0]   tex_s;

  assign cfg_ready_o = 1'b1;
  assign advance     = !b_valid_q || push_ready_i;
  assign in_ready_o  = advance;
  assign accept      = in_valid_i && advance;
  assign accept_vtx  = accept && (in_req_i.action == tpa_pkg::ActVertex);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= 1'b0;
      depth_q   <= '0;
      inv_q     <= 31'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tpa_pkg::CfgReverse:   reverse_q <= cfg_data_i[0];
        tpa_pkg::CfgDepth:     depth_q   <= $signed(cfg_data_i[31:0]);
        tpa_pkg::CfgInvHeight: inv_q     <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign tri_done = (fill_q == tpa_pkg::LastCorner);
  assign fill_inc = tri_done ? '0 : fill_q + 1'b1;

  always_comb begin
    for (int k = 0; k < tpa_pkg::NumCorners; k++) begin
      emit_order[k] = reverse_q ? order_q[tpa_pkg::NumCorners - 1 - k] : order_q[k];
    end
  end

  always_comb begin
    fill_d  = fill_q;
    order_d = order_q;
    mode_d  = mode_q;
    if (accept) begin
      case (in_req_i.action)
        tpa_pkg::ActBegin: begin
          mode_d = in_req_i.prim_kind;
          fill_d = '0;
        end
        tpa_pkg::ActEnd: begin
          fill_d = '0;
        end
        tpa_pkg::ActVertex: begin
          fill_d = fill_inc;
          if (tri_done) begin
            case (mode_q)
              tpa_pkg::PrimFan: begin
                order_d[1] = order_q[2];
                order_d[2] = order_q[1];
                fill_d     = tpa_pkg::LastCorner;
              end
              tpa_pkg::PrimStrip: begin
                order_d[0] = order_q[1];
                order_d[1] = order_q[2];
                order_d[2] = order_q[0];
                fill_d     = tpa_pkg::LastCorner;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      mode_q <= '0;
      for (int k = 0; k < tpa_pkg::NumCorners; k++) begin
        order_q[k] <= tpa_pkg::SlotW'(k);
      end
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      order_q <= order_d;
      mode_q  <= mode_d;
      if (advance) begin
        a_valid_q <= accept_vtx;
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_x_q      <= tpa_pkg::sat_add(in_req_i.vertex_x, in_req_i.origin_x);
      a_y_q      <= tpa_pkg::sat_add(in_req_i.vertex_y, in_req_i.origin_y);
      a_z_q      <= depth_q;
      a_slot_q   <= order_q[fill_q];
      a_emit_q   <= tri_done;
      a_order_q  <= emit_order;
      b_x_q      <= a_x_q;
      b_y_q      <= a_y_q;
      b_z_q      <= a_z_q;
      b_prod_s_q <= 64'(a_x_q) * 64'($signed({1'b0, inv_q}));
      b_prod_t_q <= 64'(a_y_q) * 64'($signed({1'b0, inv_q}));
      b_slot_q   <= a_slot_q;
      b_emit_q   <= a_emit_q;
      b_order_q  <= a_order_q;
    end
  end

  assign tex_s = tpa_pkg::tex_scale(b_prod_s_q);

  assign push_valid_o       = b_valid_q;
  assign push_rec_o.vtx.x   = b_x_q;
  assign push_rec_o.vtx.y   = b_y_q;
  assign push_rec_o.vtx.z   = b_z_q;
  assign push_rec_o.vtx.s   = reverse_q ? tpa_pkg::neg_sat(tex_s) : tex_s;
  assign push_rec_o.vtx.t   = tpa_pkg::tex_scale(b_prod_t_q);
  assign push_rec_o.slot    = b_slot_q;
  assign push_rec_o.emit    = b_emit_q;
  assign push_rec_o.order   = b_order_q;

endmodule

// File: hw/rtl/tpa_queue.sv
// Short first-in first-out queue of vertex records between front and back end.
module tpa_queue #(
  parameter int unsigned Depth = tpa_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tpa_pkg::rec_t push_rec_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tpa_pkg::rec_t pop_rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tpa_pkg::rec_t   entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_rec_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

// File: hw/rtl/tpa_back.sv
// Back end: vertex slot store and emission of the three corners of each triangle.
module tpa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  tpa_pkg::rec_t     pop_rec_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tpa_pkg::out_req_t out_req_o
);

  tpa_pkg::vtx_t      slots_q [tpa_pkg::NumCorners];
  tpa_pkg::slot_idx_t corner_q;
  logic               out_valid_q;
  tpa_pkg::out_req_t  out_q, out_d;
  logic               load_ok, emit_go, last_corner, pop;
  tpa_pkg::slot_idx_t rd_idx;
  tpa_pkg::vtx_t      rd_vtx;

  assign load_ok     = !out_valid_q || out_ready_i;
  assign last_corner = (corner_q == tpa_pkg::LastCorner);
  assign emit_go     = pop_valid_i && pop_rec_i.emit && load_ok;
  assign pop_ready_o = !pop_rec_i.emit || (load_ok && last_corner);
  assign pop         = pop_valid_i && pop_ready_o;

  // The vertex that completes the triangle is read from the queue head.
  assign rd_idx = pop_rec_i.order[corner_q];
  assign rd_vtx = (rd_idx == pop_rec_i.slot) ? pop_rec_i.vtx : slots_q[rd_idx];

  always_comb begin
    out_d.corner = corner_q;
    out_d.pos_x  = rd_vtx.x;
    out_d.pos_y  = rd_vtx.y;
    out_d.pos_z  = rd_vtx.z;
    out_d.tex_s  = rd_vtx.s;
    out_d.tex_t  = rd_vtx.t;
    out_d.last   = last_corner;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_go) begin
        corner_q    <= last_corner ? '0 : corner_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q <= out_d;
    end
    if (pop) begin
      slots_q[pop_rec_i.slot] <= pop_rec_i.vtx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// File: hw/rtl/triangle_primitive_assembler_unit.sv
// Top level of the triangle primitive assembler.
// The block takes one request per cycle unless the queue is full. Begin and end
// requests only update the primitive bookkeeping; a vertex request passes an adder
// stage and a multiplier stage and then waits in a queue of QueueDepth entries. The
// back end holds a vertex that closes a triangle at the queue head until its three
// corners have left, one after another, on the single output port, so a stream of
// fan or strip vertices is paced by that port while later vertices fill the queue.
// A triangle's first corner passes the adder stage, the multiplier stage, the queue
// and the output register after its last vertex is accepted. Configuration writes
// are taken every cycle and must only be issued while no request is in flight.
module triangle_primitive_assembler_unit #(
  parameter int unsigned QueueDepth = tpa_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tpa_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tpa_pkg::out_req_t             out_req_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tpa_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  tpa_pkg::rec_t push_rec, pop_rec;

  tpa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_rec_o   (push_rec)
  );

  tpa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_rec_o    (pop_rec)
  );

  tpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_rec_i   (pop_rec),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

// File: hw/rtl/tpa_checker.sv
// Port-level checker of the triangle primitive assembler and its bind statement.
`include "triangle_primitive_assembler_unit_macros.svh"

module tpa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input tpa_pkg::out_req_t out_req_i
);

  logic       out_fire, out_stall, mid_fire, last_fire;
  logic       last_ok, step_ok, restart_ok;
  logic [1:0] next_corner_q;

  assign out_fire   = out_valid_i && out_ready_i;
  assign out_stall  = out_valid_i && !out_ready_i;
  assign mid_fire   = out_fire && !out_req_i.last;
  assign last_fire  = out_fire && out_req_i.last;
  assign last_ok    = out_req_i.last == (out_req_i.corner == tpa_pkg::LastCorner);
  assign step_ok    = out_valid_i && (out_req_i.corner == next_corner_q);
  assign restart_ok = !out_valid_i || (out_req_i.corner == '0);

  always_ff @(posedge clk_i) begin
    next_corner_q <= out_req_i.corner + 2'd1;
  end

  `TPA_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(out_req_i))

  `TPA_ASSERT_NOW(a_last_on_final_corner, out_valid_i, last_ok)

  `TPA_ASSERT_NEXT(a_corners_back_to_back, mid_fire, step_ok)

  `TPA_ASSERT_NEXT(a_new_triangle_starts_at_zero, last_fire, restart_ok)

endmodule

bind triangle_primitive_assembler_unit tpa_checker u_tpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_req_i   (out_req_o)
);

// File: verif/triangle_primitive_assembler_unit_test.sv
// Self-checking testbench for the triangle primitive assembler: random requests, scoreboard.
`timescale 1ns / 1ps

module triangle_primitive_assembler_unit_test;

  localparam logic [1:0] ActUnused     = 2'd3;
  localparam logic [1:0] PrimTriangles = 2'd0;
  localparam logic [1:0] PrimOther     = 2'd3;

  localparam logic signed [31:0] CoordMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] CoordMin = 32'sh8000_0000;
  localparam longint WideMax = 64'sh7fff_ffff;
  localparam longint WideMin = -64'sh8000_0000;

  localparam int unsigned SettleCycles   = 10;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned RandomPhases   = 8;
  localparam int unsigned PhaseRequests  = 14;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] s;
    logic signed [31:0] t;
  } stored_vertex_t;

  class corner_board;
    stored_vertex_t     slot_q[3];
    int unsigned        slot_order_q[3];
    int unsigned        fill;
    logic [1:0]         mode;
    logic               back_face;
    logic signed [31:0] depth;
    logic [30:0]        inv_h;
    tpa_pkg::out_req_t  corners_due[$];
    int unsigned        errors;

    function new();
      int i;
      for (i = 0; i < 3; i++) begin
        slot_q[i] = '0;
        slot_order_q[i] = i;
      end
      fill = 0;
      mode = PrimTriangles;
      back_face = 1'b0;
      depth = '0;
      inv_h = 31'd65536;
      errors = 0;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > WideMax) return CoordMax;
      if (v < WideMin) return CoordMin;
      return v[31:0];
    endfunction

    function logic signed [31:0] to_tex(logic signed [31:0] p);
      longint prod;
      prod = longint'(p) * longint'({1'b0, inv_h});
      return clamp32(prod >>> 16);
    endfunction

    function void write_register(logic [tpa_pkg::CfgIdxW-1:0] idx,
                                 logic [tpa_pkg::CfgDataW-1:0] data);
      case (idx)
        tpa_pkg::CfgReverse:   back_face = data[0];
        tpa_pkg::CfgDepth:     depth = data;
        tpa_pkg::CfgInvHeight: inv_h = data[30:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return corners_due.size();
    endfunction

    function void add_vertex(tpa_pkg::in_req_t r);
      stored_vertex_t    v;
      tpa_pkg::out_req_t c;
      int unsigned       pick;
      int unsigned       keep;
      int                k;
      v.x = clamp32(longint'(r.vertex_x) + longint'(r.origin_x));
      v.y = clamp32(longint'(r.vertex_y) + longint'(r.origin_y));
      v.z = depth;
      v.s = to_tex(v.x);
      v.t = to_tex(v.y);
      if (back_face) begin
        v.s = (v.s == CoordMin) ? CoordMax : -v.s;
      end
      slot_q[slot_order_q[fill]] = v;
      fill = (fill + 1) % 3;
      if (fill != 0) return;
      for (k = 0; k < 3; k++) begin
        pick = back_face ? slot_order_q[2 - k] : slot_order_q[k];
        c.corner = 2'(k);
        c.pos_x = slot_q[pick].x;
        c.pos_y = slot_q[pick].y;
        c.pos_z = slot_q[pick].z;
        c.tex_s = slot_q[pick].s;
        c.tex_t = slot_q[pick].t;
        c.last = (k == 2);
        corners_due.push_back(c);
      end
      if (mode == tpa_pkg::PrimFan) begin
        keep = slot_order_q[1];
        slot_order_q[1] = slot_order_q[2];
        slot_order_q[2] = keep;
        fill = 2;
      end else if (mode == tpa_pkg::PrimStrip) begin
        keep = slot_order_q[0];
        slot_order_q[0] = slot_order_q[1];
        slot_order_q[1] = slot_order_q[2];
        slot_order_q[2] = keep;
        fill = 2;
      end
    endfunction

    function void note_request(tpa_pkg::in_req_t r);
      case (r.action)
        tpa_pkg::ActBegin: begin
          mode = r.prim_kind;
          fill = 0;
        end
        tpa_pkg::ActEnd:    fill = 0;
        tpa_pkg::ActVertex: add_vertex(r);
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t ns: %s", $time, what);
    endtask

    task check_corner(tpa_pkg::out_req_t got);
      tpa_pkg::out_req_t want;
      string             diffs;
      if (corners_due.size() == 0) begin
        report_mismatch($sformatf("unexpected corner %0d x %0d y %0d", got.corner,
                                  got.pos_x, got.pos_y));
        return;
      end
      want = corners_due.pop_front();
      diffs = "";
      if (got.corner !== want.corner)
        diffs = {diffs, $sformatf(" corner %0d/%0d", got.corner, want.corner)};
      if (got.pos_x !== want.pos_x)
        diffs = {diffs, $sformatf(" pos_x %0d/%0d", got.pos_x, want.pos_x)};
      if (got.pos_y !== want.pos_y)
        diffs = {diffs, $sformatf(" pos_y %0d/%0d", got.pos_y, want.pos_y)};
      if (got.pos_z !== want.pos_z)
        diffs = {diffs, $sformatf(" pos_z %0d/%0d", got.pos_z, want.pos_z)};
      if (got.tex_s !== want.tex_s)
        diffs = {diffs, $sformatf(" tex_s %0d/%0d", got.tex_s, want.tex_s)};
      if (got.tex_t !== want.tex_t)
        diffs = {diffs, $sformatf(" tex_t %0d/%0d", got.tex_t, want.tex_t)};
      if (got.last !== want.last)
        diffs = {diffs, $sformatf(" last %0d/%0d", got.last, want.last)};
      if (diffs != "") begin
        report_mismatch({"corner mismatch (got/expected):", diffs});
      end
    endtask

    task close_out();
      if (corners_due.size() != 0) begin
        report_mismatch($sformatf("%0d expected corners never arrived", corners_due.size()));
      end
    endtask
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  tpa_pkg::in_req_t             in_req_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  tpa_pkg::out_req_t            out_req_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [tpa_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [tpa_pkg::CfgDataW-1:0] cfg_data_i = '0;

  corner_board board = new();
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned quiet_cycles = 0;

  triangle_primitive_assembler_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_corner(out_req_o);
        rx_wait = rx_steady ? 0 : $urandom_range(0, 17);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[triangle_primitive_assembler_unit] ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_wait > 0) begin
      out_ready_i <= 1'b0;
      rx_wait--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic signed [31:0] pick_coord();
    logic signed [31:0] w;
    case ($urandom_range(0, 9))
      0: w = CoordMax;
      1: w = CoordMin;
      2: w = '0;
      3: w = -32'sd1;
      4, 5: w = $urandom_range(0, 32'h0020_0000) - 32'sh0010_0000;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic tpa_pkg::in_req_t vertex_req(logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] ox,
                                                  logic signed [31:0] oy);
    tpa_pkg::in_req_t r;
    r.action = tpa_pkg::ActVertex;
    r.prim_kind = 2'($urandom);
    r.vertex_x = x;
    r.vertex_y = y;
    r.origin_x = ox;
    r.origin_y = oy;
    return r;
  endfunction

  function automatic tpa_pkg::in_req_t marker_req(logic [1:0] act, logic [1:0] kind);
    tpa_pkg::in_req_t r;
    r = vertex_req(pick_coord(), pick_coord(), pick_coord(), pick_coord());
    r.action = act;
    r.prim_kind = kind;
    return r;
  endfunction

  function automatic tpa_pkg::in_req_t random_vertex();
    return vertex_req(pick_coord(), pick_coord(), pick_coord(), pick_coord());
  endfunction

  // Entered and left at a falling edge; valid stays high only when the next request follows.
  task automatic push_request(input tpa_pkg::in_req_t r);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic drain_corners();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (board.pending() != 0);
  endtask

  task automatic write_register(input logic [tpa_pkg::CfgIdxW-1:0] idx,
                                input logic [tpa_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_register(idx, data);
    @(negedge clk_i);
  endtask

  // Begin and end requests leave no result to wait for, so allow the pipeline to empty.
  task automatic reconfigure(input logic [31:0] rev, input logic [31:0] z,
                             input logic [31:0] inv);
    drain_corners();
    repeat (SettleCycles) @(negedge clk_i);
    write_register(tpa_pkg::CfgReverse, rev);
    write_register(tpa_pkg::CfgDepth, z);
    write_register(tpa_pkg::CfgInvHeight, inv);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    // Saturating adds and an ignored request.
    push_request(marker_req(tpa_pkg::ActBegin, PrimTriangles));
    push_request(vertex_req(CoordMax, CoordMin, CoordMax, CoordMin));
    push_request(vertex_req(-32'sd1, 32'sd1, '0, '0));
    push_request(vertex_req('0, '0, '0, '0));
    push_request(marker_req(ActUnused, 2'($urandom)));
    push_request(vertex_req(32'sd5, 32'sd6, 32'sd7, 32'sd8));
    push_request(random_vertex());
    push_request(marker_req(tpa_pkg::ActEnd, 2'($urandom)));
    push_request(marker_req(tpa_pkg::ActBegin, tpa_pkg::PrimFan));
    repeat (4) push_request(random_vertex());
    // Back face with a gain just above one: s of the most negative position saturates to maximum.
    reconfigure(32'd1, CoordMin, 32'h0001_0001);
    push_request(marker_req(tpa_pkg::ActBegin, tpa_pkg::PrimStrip));
    push_request(vertex_req(CoordMin, CoordMin, '0, '0));
    push_request(vertex_req(-32'sd1, -32'sd1, '0, '0));
    push_request(vertex_req(32'sd1, 32'sd1, '0, '0));
    push_request(vertex_req(CoordMax, CoordMax, '0, '0));
    push_request(marker_req(tpa_pkg::ActBegin, PrimOther));
    repeat (3) push_request(random_vertex());
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned      sent;
    int unsigned      len;
    int unsigned      roll;
    tpa_pkg::in_req_t r;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 15) == 0) drain_corners();
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        push_request(marker_req(tpa_pkg::ActBegin, 2'($urandom_range(0, 3))));
        len = $urandom_range(1, 7);
        repeat (len) push_request(random_vertex());
        sent += len + 1;
        if ($urandom_range(0, 1) == 1) begin
          push_request(marker_req(tpa_pkg::ActEnd, 2'($urandom)));
          sent++;
        end
      end else if (roll == 7) begin
        len = $urandom_range(1, 4);
        repeat (len) push_request(random_vertex());
        sent += len;
      end else begin
        r = marker_req(2'($urandom_range(0, 3)), 2'($urandom));
        push_request(r);
        if (r.action != ActUnused) sent++;
      end
    end
  endtask

  function automatic logic [31:0] random_inv_height();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'h0001_0000 + $urandom_range(0, 32'h0000_ffff);
      2: return $urandom_range(0, 32'h0002_0000);
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  initial begin
    int unsigned phase;
    logic [31:0] z;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    for (phase = 1; phase <= RandomPhases; phase++) begin
      case (phase)
        1: reconfigure(32'd0, CoordMax, 32'h7fff_ffff);
        2: reconfigure(32'd1, '0, 32'h0000_0000);
        3: reconfigure(32'hffff_fffe, CoordMin, 32'h8001_0000);
        default: begin
          z = ($urandom_range(0, 3) == 0) ? CoordMax : $urandom;
          reconfigure($urandom, z, random_inv_height());
        end
      endcase
      tx_steady = (phase == 1) || (phase % 3 == 2);
      rx_steady = (phase == 1) || (phase % 4 == 3);
      run_random(PhaseRequests);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain_corners();
    repeat (SettleCycles) @(negedge clk_i);
    board.close_out();
    if (board.errors == 0) begin
      $display("[triangle_primitive_assembler_unit] OK");
    end else begin
      $display("[triangle_primitive_assembler_unit] ERROR");
    end
    $finish;
  end

endmodule
